>>> hdl/dsc_pkg.sv
// shared types, codes and default sizes for the dictionary slice compactor
package dsc_pkg;

  localparam int DICT_DEPTH_DEF = 16;
  localparam int POS_DEPTH_DEF  = 32;

  localparam int VALUE_W     = 64;
  localparam int INDEX_W     = 4;
  localparam int ACTION_W    = 2;
  localparam int KIND_W      = 2;
  localparam int OFFSET_W    = 5;
  localparam int COUNT_W     = 6;
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 6;

  localparam logic [ACTION_W-1:0] ACT_LOAD_ENTRY = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_LOAD_POS   = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_FINISH     = 2'd2;

  localparam logic [KIND_W-1:0] KIND_ENTRY = 2'd0;
  localparam logic [KIND_W-1:0] KIND_POS   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_END   = 2'd2;

  localparam logic [CFG_INDEX_W-1:0] CFG_SLICE_OFFSET = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_SLICE_COUNT  = 1'b1;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [VALUE_W-1:0]  entry_value;
    logic                entry_is_null;
    logic [INDEX_W-1:0]  position_index;
    logic                position_is_null;
  } in_item_t;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [VALUE_W-1:0] value;
    logic               value_is_null;
    logic [INDEX_W-1:0] new_index;
    logic               index_is_null;
    logic               overflow;
    logic               last;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MARK,
    ST_DICT,
    ST_POS,
    ST_END
  } state_t;

  typedef enum logic [2:0] {
    TAG_NONE,
    TAG_MARK,
    TAG_DICT,
    TAG_POS,
    TAG_END
  } tag_t;

  typedef struct packed {
    logic load_entry;
    logic load_pos;
    logic setup;
    logic mark;
    logic rewind;
    logic dict;
    logic pos;
    logic fin;
  } dp_cmd_t;

  typedef struct packed {
    logic pos_done;
    logic dict_done;
  } dp_stat_t;

endpackage

>>> hdl/dsc_ram.sv
// generic simple dual-port ram with registered read
module dsc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> hdl/dsc_ctrl.sv
// sequencer for loads and the mark, dictionary and position walks of a finish
module dsc_ctrl
  import dsc_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [ACTION_W-1:0] action,
  input  dp_stat_t            stat,
  output dp_cmd_t             cmd,
  output logic                busy
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    busy      = (state_r != ST_IDLE);
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          unique case (action)
            ACT_LOAD_ENTRY: cmd.load_entry = 1'b1;
            ACT_LOAD_POS:   cmd.load_pos   = 1'b1;
            ACT_FINISH: begin
              cmd.setup = 1'b1;
              state_nxt = ST_MARK;
            end
            default: ;
          endcase
        end
      end
      ST_MARK: begin
        if (stat.pos_done) begin
          cmd.rewind = 1'b1;
          state_nxt  = ST_DICT;
        end else begin
          cmd.mark = 1'b1;
        end
      end
      ST_DICT: begin
        if (stat.dict_done) begin
          state_nxt = ST_POS;
        end else begin
          cmd.dict = 1'b1;
        end
      end
      ST_POS: begin
        if (stat.pos_done) begin
          state_nxt = ST_END;
        end else begin
          cmd.pos = 1'b1;
        end
      end
      ST_END: begin
        cmd.fin   = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

>>> hdl/dsc_datapath.sv
// stores, counters, used marks, remap table and result register
module dsc_datapath
  import dsc_pkg::*;
#(
  parameter int DICT_DEPTH = DICT_DEPTH_DEF,
  parameter int POS_DEPTH  = POS_DEPTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  in_item_t               in_data,
  input  dp_cmd_t                cmd,
  output dp_stat_t               stat,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output logic                   out_valid,
  output out_item_t              out_data
);

  localparam int DICT_AW = $clog2(DICT_DEPTH);
  localparam int DICT_CW = $clog2(DICT_DEPTH + 1);
  localparam int POS_AW  = $clog2(POS_DEPTH);
  localparam int POS_CW  = $clog2(POS_DEPTH + 1);
  localparam int USED_N  = (DICT_DEPTH < (2 ** INDEX_W)) ? DICT_DEPTH : (2 ** INDEX_W);
  localparam int USED_AW = $clog2(USED_N);
  localparam int USED_CW = $clog2(USED_N + 1);
  localparam int IXW     = (DICT_CW > INDEX_W) ? DICT_CW : INDEX_W;
  localparam int LW      = ((POS_CW > COUNT_W) ? POS_CW : COUNT_W) + 1;

  logic [DICT_CW-1:0]  dict_loaded_r, dict_loaded_nxt;
  logic [POS_CW-1:0]   pos_loaded_r, pos_loaded_nxt;
  logic                dropped_r, dropped_nxt;
  logic [OFFSET_W-1:0] offset_r;
  logic [COUNT_W-1:0]  count_r;
  logic [POS_CW-1:0]   start_r, start_nxt;
  logic [POS_CW-1:0]   end_r, end_nxt;
  logic [POS_CW-1:0]   ptr_r, ptr_nxt;
  logic [USED_CW-1:0]  di_r, di_nxt;
  logic [INDEX_W-1:0]  next_r, next_nxt;
  logic [USED_N-1:0]   used_r, used_nxt;
  logic [INDEX_W-1:0]  remap_r [USED_N];
  logic [INDEX_W-1:0]  remap_nxt [USED_N];
  tag_t                s1_tag_r, s1_tag_nxt;
  logic [USED_AW-1:0]  s1_idx_r, s1_idx_nxt;
  logic                out_valid_r, out_valid_nxt;
  out_item_t           out_r, out_nxt;

  logic                   dict_room, pos_room;
  logic [VALUE_W:0]       dict_rdata;
  logic [INDEX_W:0]       pos_rdata;
  logic [VALUE_W-1:0]     rd_val;
  logic                   rd_vnull;
  logic [INDEX_W-1:0]     rd_pidx;
  logic                   rd_pnull;
  logic                   pvalid;
  logic [USED_AW-1:0]     pslot;
  logic [IXW-1:0]         dict_lim;
  logic [LW-1:0]          offw, plw, cntw, room, len;

  assign dict_room = (dict_loaded_r < DICT_CW'(DICT_DEPTH));
  assign pos_room  = (pos_loaded_r < POS_CW'(POS_DEPTH));

  dsc_ram #(.WIDTH(VALUE_W + 1), .DEPTH(DICT_DEPTH)) u_dict_ram (
    .clk   (clk),
    .we    (cmd.load_entry && dict_room),
    .waddr (DICT_AW'(dict_loaded_r)),
    .wdata ({in_data.entry_value, in_data.entry_is_null}),
    .raddr (DICT_AW'(di_r)),
    .rdata (dict_rdata)
  );

  dsc_ram #(.WIDTH(INDEX_W + 1), .DEPTH(POS_DEPTH)) u_pos_ram (
    .clk   (clk),
    .we    (cmd.load_pos && pos_room),
    .waddr (POS_AW'(pos_loaded_r)),
    .wdata ({in_data.position_index, in_data.position_is_null}),
    .raddr (POS_AW'(ptr_r)),
    .rdata (pos_rdata)
  );

  assign {rd_val, rd_vnull}  = dict_rdata;
  assign {rd_pidx, rd_pnull} = pos_rdata;
  assign pvalid = !rd_pnull && (IXW'(rd_pidx) < IXW'(dict_loaded_r));
  assign pslot  = USED_AW'(rd_pidx);

  // only the first entries can be referenced by a 4-bit position index
  assign dict_lim = (IXW'(dict_loaded_r) < IXW'(USED_N)) ? IXW'(dict_loaded_r) : IXW'(USED_N);

  assign stat.pos_done  = (ptr_r == end_r);
  assign stat.dict_done = (IXW'(di_r) == dict_lim);

  // slice bounds clipped to the loaded positions
  assign offw = LW'(offset_r);
  assign plw  = LW'(pos_loaded_r);
  assign cntw = LW'(count_r);
  assign room = plw - offw;
  assign len  = (offw >= plw) ? '0 : ((cntw < room) ? cntw : room);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r <= '0;
      count_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SLICE_OFFSET: offset_r <= cfg_data[OFFSET_W-1:0];
        CFG_SLICE_COUNT:  count_r  <= cfg_data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    dict_loaded_nxt = dict_loaded_r;
    pos_loaded_nxt  = pos_loaded_r;
    dropped_nxt     = dropped_r;
    start_nxt       = start_r;
    end_nxt         = end_r;
    ptr_nxt         = ptr_r;
    di_nxt          = di_r;
    next_nxt        = next_r;
    used_nxt        = used_r;
    remap_nxt       = remap_r;
    s1_tag_nxt      = TAG_NONE;
    s1_idx_nxt      = s1_idx_r;
    out_valid_nxt   = 1'b0;
    out_nxt         = out_r;

    if (cmd.load_entry) begin
      if (dict_room) begin
        dict_loaded_nxt = dict_loaded_r + 1'b1;
      end else begin
        dropped_nxt = 1'b1;
      end
    end
    if (cmd.load_pos) begin
      if (pos_room) begin
        pos_loaded_nxt = pos_loaded_r + 1'b1;
      end else begin
        dropped_nxt = 1'b1;
      end
    end

    if (cmd.setup) begin
      if (offw >= plw) begin
        start_nxt = '0;
        end_nxt   = '0;
        ptr_nxt   = '0;
      end else begin
        start_nxt = POS_CW'(offw);
        end_nxt   = POS_CW'(offw + len);
        ptr_nxt   = POS_CW'(offw);
      end
      used_nxt = '0;
      di_nxt   = '0;
      next_nxt = '0;
    end

    // read issue
    if (cmd.mark) begin
      ptr_nxt    = ptr_r + 1'b1;
      s1_tag_nxt = TAG_MARK;
    end else if (cmd.rewind) begin
      ptr_nxt = start_r;
    end else if (cmd.dict) begin
      di_nxt     = di_r + 1'b1;
      s1_idx_nxt = USED_AW'(di_r);
      s1_tag_nxt = TAG_DICT;
    end else if (cmd.pos) begin
      ptr_nxt    = ptr_r + 1'b1;
      s1_tag_nxt = TAG_POS;
    end else if (cmd.fin) begin
      s1_tag_nxt = TAG_END;
    end

    // read data return
    case (s1_tag_r)
      TAG_MARK: begin
        if (pvalid) begin
          used_nxt[pslot] = 1'b1;
        end
      end
      TAG_DICT: begin
        if (used_r[s1_idx_r]) begin
          remap_nxt[s1_idx_r] = next_r;
          next_nxt            = next_r + 1'b1;
          out_valid_nxt       = 1'b1;
          out_nxt             = '0;
          out_nxt.kind        = KIND_ENTRY;
          out_nxt.value       = rd_vnull ? '0 : rd_val;
          out_nxt.value_is_null = rd_vnull;
        end
      end
      TAG_POS: begin
        out_valid_nxt         = 1'b1;
        out_nxt               = '0;
        out_nxt.kind          = KIND_POS;
        out_nxt.new_index     = pvalid ? remap_r[pslot] : '0;
        out_nxt.index_is_null = !pvalid;
      end
      TAG_END: begin
        out_valid_nxt    = 1'b1;
        out_nxt          = '0;
        out_nxt.kind     = KIND_END;
        out_nxt.overflow = dropped_r;
        out_nxt.last     = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dict_loaded_r <= '0;
      pos_loaded_r  <= '0;
      dropped_r     <= 1'b0;
      start_r       <= '0;
      end_r         <= '0;
      ptr_r         <= '0;
      di_r          <= '0;
      next_r        <= '0;
      used_r        <= '0;
      s1_tag_r      <= TAG_NONE;
      out_valid_r   <= 1'b0;
    end else begin
      dict_loaded_r <= dict_loaded_nxt;
      pos_loaded_r  <= pos_loaded_nxt;
      dropped_r     <= dropped_nxt;
      start_r       <= start_nxt;
      end_r         <= end_nxt;
      ptr_r         <= ptr_nxt;
      di_r          <= di_nxt;
      next_r        <= next_nxt;
      used_r        <= used_nxt;
      s1_tag_r      <= s1_tag_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    remap_r  <= remap_nxt;
    s1_idx_r <= s1_idx_nxt;
    out_r    <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_ptr_in_slice: assert property (@(posedge clk) disable iff (!rst_n)
    (start_r <= end_r) && (ptr_r <= end_r))
    else $error("slice pointer left its bounds");

  a_dict_count: assert property (@(posedge clk) disable iff (!rst_n)
    dict_loaded_r <= DICT_CW'(DICT_DEPTH))
    else $error("dictionary count beyond capacity");

  a_end_alone: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_r.kind == KIND_END)) |=> !out_valid_r)
    else $error("result right after end marker");

endmodule

>>> hdl/dictionary_slice_compactor.sv
// top level of the dictionary slice compactor: controller, datapath and ports
// loads (entry or position) are taken one per cycle while not busy, no result
// a finish makes one pass over the clipped slice to mark, one over the first
// min(entries loaded, 16) dictionary entries, and one more over the slice,
// each through the registered-read stores
// results leave at most one per cycle on out_valid, the receiver cannot stall them
// synchronous active-low reset clears counts, drop flag, slice registers, state
module dictionary_slice_compactor
  import dsc_pkg::*;
#(
  parameter int DICT_DEPTH = DICT_DEPTH_DEF,
  parameter int POS_DEPTH  = POS_DEPTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // input command channel
  input  logic                   start,
  output logic                   busy,
  input  in_item_t               in_data,
  // result channel, one cycle strobe per transfer
  output logic                   out_valid,
  output out_item_t              out_data,
  // configuration write channel
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // slice registers accept a transfer in any cycle
  assign cfg_ready = 1'b1;

  // sequencer: decodes the command and steps through the three walks
  dsc_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .action (in_data.action),
    .stat   (stat),
    .cmd    (cmd),
    .busy   (busy)
  );

  // stores, walk counters, marks, remap and the result register
  dsc_datapath #(
    .DICT_DEPTH (DICT_DEPTH),
    .POS_DEPTH  (POS_DEPTH)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

>>> verif/dictionary_slice_compactor_tb.sv
// self-checking testbench for the dictionary slice compactor
`timescale 1ns / 1ps

module dictionary_slice_compactor_tb;
  import dsc_pkg::*;

  // action code that the block must ignore: no result, no state change
  localparam logic [ACTION_W-1:0] ACT_IGNORED = 2'd3;

  localparam int ERR_SHOW        = 10;   // mismatches printed in full
  localparam int IDLE_LIMIT      = 2000; // cycles without any transfer before giving up
  localparam int SETTLE_CYCLES   = 4;    // quiet cycles before a register write
  localparam int TAIL_CYCLES     = 100;  // watch for stray results at the end
  localparam int RAND_PHASES     = 8;
  localparam int ITEMS_PER_PHASE = 22;

  // ---------------------------------------------------------------------------
  // scoreboard: keeps its own copy of the loaded column and the slice registers,
  // predicts the result run of every finish and checks results in order
  // ---------------------------------------------------------------------------
  class compactor_scoreboard;
    logic [VALUE_W-1:0] entry_val  [DICT_DEPTH_DEF];
    logic               entry_null [DICT_DEPTH_DEF];
    int unsigned        entries_loaded;
    logic [INDEX_W-1:0] pos_idx    [POS_DEPTH_DEF];
    logic               pos_null   [POS_DEPTH_DEF];
    int unsigned        positions_loaded;
    logic               dropped;
    logic [OFFSET_W-1:0] slice_offset;
    logic [COUNT_W-1:0]  slice_count;

    out_item_t   expected_q[$];
    int unsigned fail_count;
    int unsigned results_checked;
    int unsigned finish_runs;
    int unsigned drop_reports;
    int unsigned cfg_writes;

    function new();
      entries_loaded   = 0;
      positions_loaded = 0;
      dropped          = 1'b0;
      slice_offset     = '0;
      slice_count      = '0;
      fail_count       = 0;
      results_checked  = 0;
      finish_runs      = 0;
      drop_reports     = 0;
      cfg_writes       = 0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // append one predicted result at the tail
    function void enqueue(out_item_t r);
      expected_q.insert(expected_q.size(), r);
    endfunction

    function string show(out_item_t r);
      return $sformatf("kind=%0d value=%h vnull=%b idx=%0d inull=%b ovf=%b last=%b",
                       r.kind, r.value, r.value_is_null, r.new_index,
                       r.index_is_null, r.overflow, r.last);
    endfunction

    function void flag(string msg);
      fail_count++;
      if (fail_count <= ERR_SHOW) $display("[%0t] mismatch: %s", $realtime, msg);
    endfunction

    function void note_config(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      cfg_writes++;
      if (idx == CFG_SLICE_OFFSET) slice_offset = data[OFFSET_W-1:0];
      else slice_count = data[COUNT_W-1:0];
    endfunction

    // a position counts only when it is not null and lands inside the loaded dictionary
    function bit position_live(int unsigned p);
      return !pos_null[p] && (pos_idx[p] < entries_loaded);
    endfunction

    function void compact_slice();
      int unsigned first;
      int unsigned len;
      int unsigned next;
      bit used[DICT_DEPTH_DEF];
      logic [INDEX_W-1:0] new_slot[DICT_DEPTH_DEF];
      out_item_t r;
      first = slice_offset;
      if (first >= positions_loaded) len = 0;
      else begin
        len = positions_loaded - first;
        if (slice_count < len) len = slice_count;
      end
      foreach (used[i]) used[i] = 1'b0;
      for (int i = 0; i < len; i++)
        if (position_live(first + i)) used[pos_idx[first + i]] = 1'b1;
      // used entries are renumbered in ascending old order
      next = 0;
      for (int i = 0; i < DICT_DEPTH_DEF; i++) begin
        new_slot[i] = '0;
        if (i < entries_loaded && used[i]) begin
          new_slot[i] = INDEX_W'(next);
          next++;
          r = '0;
          r.kind          = KIND_ENTRY;
          r.value         = entry_null[i] ? '0 : entry_val[i];
          r.value_is_null = entry_null[i];
          enqueue(r);
        end
      end
      for (int i = 0; i < len; i++) begin
        r = '0;
        r.kind = KIND_POS;
        if (position_live(first + i)) r.new_index = new_slot[pos_idx[first + i]];
        else r.index_is_null = 1'b1;
        enqueue(r);
      end
      r = '0;
      r.kind     = KIND_END;
      r.overflow = dropped;
      r.last     = 1'b1;
      enqueue(r);
      finish_runs++;
      if (dropped) drop_reports++;
    endfunction

    function void note_item(in_item_t it);
      case (it.action)
        ACT_LOAD_ENTRY: begin
          if (entries_loaded < DICT_DEPTH_DEF) begin
            entry_val[entries_loaded]  = it.entry_value;
            entry_null[entries_loaded] = it.entry_is_null;
            entries_loaded++;
          end else dropped = 1'b1;
        end
        ACT_LOAD_POS: begin
          if (positions_loaded < POS_DEPTH_DEF) begin
            pos_idx[positions_loaded]  = it.position_index;
            pos_null[positions_loaded] = it.position_is_null;
            positions_loaded++;
          end else dropped = 1'b1;
        end
        ACT_FINISH: compact_slice();
        default: ;
      endcase
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (expected_q.size() == 0) begin
        flag({"result with nothing pending: ", show(got)});
        return;
      end
      want = expected_q.pop_front();
      results_checked++;
      if (got.kind !== want.kind || got.value !== want.value ||
          got.value_is_null !== want.value_is_null || got.new_index !== want.new_index ||
          got.index_is_null !== want.index_is_null || got.overflow !== want.overflow ||
          got.last !== want.last)
        flag($sformatf("result %0d expected %s got %s", results_checked, show(want), show(got)));
    endfunction

    function void check_drained();
      if (expected_q.size() != 0)
        flag($sformatf("%0d results never arrived, oldest %s",
                       expected_q.size(), show(expected_q[0])));
    endfunction
  endclass

  // ---------------------------------------------------------------------------
  // block under test
  // ---------------------------------------------------------------------------
  logic                   clk       = 1'b0;
  logic                   rst_n     = 1'b0;
  logic                   start     = 1'b0;
  logic                   busy;
  in_item_t               in_data   = '0;
  logic                   out_valid;
  out_item_t              out_data;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data  = '0;

  compactor_scoreboard sb = new();

  int unsigned idle_cycles = 0;
  int unsigned sent_items  = 0;
  bit          no_gaps     = 1'b0;

  dictionary_slice_compactor dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // monitor: everything is sampled at the rising edge, before the block's own
  // updates land, so each transfer is seen exactly as the block takes it
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    bit moved;
    moved = 1'b0;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        sb.note_config(cfg_index, cfg_data);
        moved = 1'b1;
      end
      // a finish can be accepted while the results of the one before are still leaving;
      // its predictions queue behind them, and checking the result first keeps the order right
      if (out_valid) begin
        sb.check_result(out_data);
        moved = 1'b1;
      end
      if (start && !busy) begin
        sb.note_item(in_data);
        moved = 1'b1;
      end
      idle_cycles <= moved ? 0 : idle_cycles + 1;
    end
  end

  // watchdog: a hung handshake or a lost result run ends the run here
  initial begin
    wait (rst_n);
    while (idle_cycles < IDLE_LIMIT) @(posedge clk);
    $display("FAIL dictionary_slice_compactor");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // drivers
  // ---------------------------------------------------------------------------

  // random content in every field, the action decides which fields matter
  function automatic in_item_t rand_item(logic [ACTION_W-1:0] act);
    in_item_t it;
    it.action           = act;
    it.entry_value      = {$urandom, $urandom};
    it.entry_is_null    = ($urandom_range(0, 3) == 0);
    it.position_index   = INDEX_W'($urandom_range(0, 15));
    it.position_is_null = ($urandom_range(0, 4) == 0);
    return it;
  endfunction

  // one command transfer; start stays high into the next item when there is no gap
  task automatic send_item(in_item_t it);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (busy);
    sent_items++;
  endtask

  task automatic send_cmd(logic [ACTION_W-1:0] act);
    send_item(rand_item(act));
  endtask

  task automatic send_entry(logic [VALUE_W-1:0] v, logic is_null);
    in_item_t it;
    it = rand_item(ACT_LOAD_ENTRY);
    it.entry_value   = v;
    it.entry_is_null = is_null;
    send_item(it);
  endtask

  task automatic send_pos(logic [INDEX_W-1:0] idx, logic is_null);
    in_item_t it;
    it = rand_item(ACT_LOAD_POS);
    it.position_index   = idx;
    it.position_is_null = is_null;
    send_item(it);
  endtask

  // hold the sender until every predicted result is back and the block is idle;
  // checked on the falling edge so the monitor's updates have settled
  task automatic settle();
    start <= 1'b0;
    do @(negedge clk); while (sb.pending() != 0 || busy);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // both slice registers, back to back; cfg_valid drops only after the second transfer
  task automatic write_slice(logic [CFG_DATA_W-1:0] off, logic [CFG_DATA_W-1:0] cnt);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_SLICE_OFFSET;
    cfg_data  <= off;
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= CFG_SLICE_COUNT;
    cfg_data  <= cnt;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  initial begin
    int counted;
    int pick;
    logic [ACTION_W-1:0] act;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty column under reset slice gives a bare end marker
    send_cmd(ACT_FINISH);
    send_cmd(ACT_IGNORED);
    settle();
    write_slice(6'd0, 6'd32);

    // dictionary extremes; the null entry carries a nonzero value that must not leak
    send_entry('0, 1'b0);
    send_entry('1, 1'b0);
    send_entry(64'hdead_beef_0bad_f00d, 1'b1);
    send_entry(64'h8000_0000_0000_0001, 1'b0);

    // entry 2 stays unused so the map is not the identity; 15 and 4 point
    // past the loaded dictionary, the null position carries a valid index
    send_pos(4'd0, 1'b0);
    send_pos(4'd3, 1'b0);
    send_pos(4'd15, 1'b0);
    send_pos(4'd1, 1'b1);
    send_pos(4'd1, 1'b0);
    send_pos(4'd0, 1'b0);
    send_pos(4'd4, 1'b0);
    send_cmd(ACT_FINISH);

    // slice starting past the loaded positions is empty
    settle();
    write_slice(6'd31, 6'd1);
    send_cmd(ACT_FINISH);

    // count far larger than what is left gets clipped
    settle();
    write_slice(6'd5, 6'd63);
    send_cmd(ACT_FINISH);

    // now every loaded entry is referenced; finish twice to see the run repeat
    settle();
    write_slice(6'd0, 6'd32);
    send_pos(4'd2, 1'b0);
    send_cmd(ACT_FINISH);
    send_cmd(ACT_FINISH);

    // random phases: loads interleaved with finishes, the slice changes between
    // phases; the stores fill early on, after that loads are dropped and flagged
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      settle();
      case ($urandom_range(0, 3))
        0: write_slice(6'd0, 6'd32);
        1: write_slice(6'd31, 6'd63);
        2: write_slice(CFG_DATA_W'($urandom_range(0, 31)),
                       CFG_DATA_W'($urandom_range(0, 32)));
        default: write_slice(CFG_DATA_W'($urandom_range(0, 63)),
                             CFG_DATA_W'($urandom_range(0, 63)));
      endcase
      // some phases run back to back with no gaps at all
      no_gaps = ($urandom_range(0, 3) == 0);
      counted = 0;
      while (counted < ITEMS_PER_PHASE) begin
        pick = $urandom_range(0, 19);
        if (pick < 6) act = ACT_LOAD_ENTRY;
        else if (pick < 14) act = ACT_LOAD_POS;
        else if (pick < 19) act = ACT_FINISH;
        else act = ACT_IGNORED;
        send_item(rand_item(act));
        if (act != ACT_IGNORED) counted++;
      end
    end

    // drain, then keep watching for anything extra
    settle();
    repeat (TAIL_CYCLES) @(posedge clk);
    sb.check_drained();

    $display("run covered %0d command transfers, %0d finishes, %0d results checked",
             sent_items, sb.finish_runs, sb.results_checked);
    $display("%0d slice register writes, %0d end markers with the drop flag, %0d mismatches",
             sb.cfg_writes, sb.drop_reports, sb.fail_count);
    if (sb.fail_count == 0) begin
      $display("PASS dictionary_slice_compactor");
    end else begin
      $display("FAIL dictionary_slice_compactor");
    end
    $finish;
  end

endmodule
